[rtl/sbq_pkg.sv]
package sbq_pkg;

  // Request kinds carried in the input tuser field.
  localparam logic [1:0] REQ_POLL   = 2'd0;
  localparam logic [1:0] REQ_INJECT = 2'd1;
  localparam logic [1:0] REQ_HOLD   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PMU_PRESENT = 2'd0;
  localparam logic [1:0] REG_BOOT_HOLD   = 2'd1;
  localparam logic [1:0] REG_SCAN_PERIOD = 2'd2;
  localparam logic [1:0] REG_EMIT_GAP    = 2'd3;

  // Register reset values.
  localparam logic [15:0] BOOT_HOLD_RST   = 16'd45;
  localparam logic [15:0] SCAN_PERIOD_RST = 16'd35;
  localparam logic [15:0] EMIT_GAP_RST    = 16'd350;

  // Event mask bits.
  localparam logic [7:0] EV_BOOT = 8'h01;
  localparam logic [7:0] EV_PWR  = 8'h02;

  typedef struct packed {
    logic        pmu_present;
    logic [15:0] boot_hold_ms;
    logic [15:0] scan_period_ms;
    logic [15:0] emit_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        boot_pressed;
    logic        key_fall_irq;
    logic        key_rise_irq;
    logic        key_short_irq;
    logic [7:0]  inject_bits;
    logic        hold_value;
  } item_t;

  typedef struct packed {
    logic [7:0] events;
    logic       key_held;
    logic       scan_done;
    logic       clear_irq;
  } result_t;

endpackage

[rtl/sbq_cfg.sv]
module sbq_cfg
  import sbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_addr,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // Register file, one write per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pmu_present    <= 1'b0;
      cfg_r.boot_hold_ms   <= BOOT_HOLD_RST;
      cfg_r.scan_period_ms <= SCAN_PERIOD_RST;
      cfg_r.emit_gap_ms    <= EMIT_GAP_RST;
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_PMU_PRESENT: cfg_r.pmu_present    <= wr_data[0];
        REG_BOOT_HOLD:   cfg_r.boot_hold_ms   <= wr_data;
        REG_SCAN_PERIOD: cfg_r.scan_period_ms <= wr_data;
        REG_EMIT_GAP:    cfg_r.emit_gap_ms    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/sbq_core.sv]
module sbq_core
  import sbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [7:0]  pending_inject_r, pending_inject_nxt;
  logic        boot_armed_r, boot_armed_nxt;
  logic        boot_start_valid_r, boot_start_valid_nxt;
  logic [31:0] boot_start_time_r, boot_start_time_nxt;
  logic [31:0] last_scan_time_r, last_scan_time_nxt;
  logic        held_latch_r, held_latch_nxt;
  logic [31:0] last_emit_time_r, last_emit_time_nxt;

  logic [31:0] boot_elapsed;
  logic [31:0] scan_elapsed;
  logic [31:0] emit_elapsed;
  logic        hold_met;
  logic        scan_due;
  logic        emit_open;

  // Elapsed times use wrapping subtraction.
  assign boot_elapsed = item.now_ms - boot_start_time_r;
  assign scan_elapsed = item.now_ms - last_scan_time_r;
  assign emit_elapsed = item.now_ms - last_emit_time_r;
  assign hold_met  = boot_elapsed >= {16'd0, cfg.boot_hold_ms};
  assign scan_due  = cfg.pmu_present && (scan_elapsed >= {16'd0, cfg.scan_period_ms});
  assign emit_open = emit_elapsed >= {16'd0, cfg.emit_gap_ms};

  // Next state and result for the item in the input register.
  always_comb begin
    logic [7:0] ev;
    logic       scanned;
    logic       clr;
    ev                   = 8'd0;
    scanned              = 1'b0;
    clr                  = 1'b0;
    pending_inject_nxt   = pending_inject_r;
    boot_armed_nxt       = boot_armed_r;
    boot_start_valid_nxt = boot_start_valid_r;
    boot_start_time_nxt  = boot_start_time_r;
    last_scan_time_nxt   = last_scan_time_r;
    held_latch_nxt       = held_latch_r;
    last_emit_time_nxt   = last_emit_time_r;

    unique case (item.req_type)
      REQ_INJECT: pending_inject_nxt = pending_inject_r | item.inject_bits;
      REQ_HOLD:   held_latch_nxt = item.hold_value;
      REQ_POLL: begin
        ev = pending_inject_r;
        pending_inject_nxt = 8'd0;

        // Boot button qualification: the first down poll only starts the timer.
        if (item.boot_pressed) begin
          if (!boot_start_valid_r) begin
            boot_start_valid_nxt = 1'b1;
            boot_start_time_nxt  = item.now_ms;
          end else if (boot_armed_r && hold_met) begin
            boot_armed_nxt = 1'b0;
            ev = ev | EV_BOOT;
          end
        end else begin
          boot_start_valid_nxt = 1'b0;
          boot_start_time_nxt  = 32'd0;
          boot_armed_nxt       = 1'b1;
        end

        // Power key scan; a rise flag wins over a fall flag.
        if (scan_due) begin
          last_scan_time_nxt = item.now_ms;
          scanned = 1'b1;
          if (item.key_fall_irq) begin
            held_latch_nxt = 1'b1;
            clr = 1'b1;
          end
          if (item.key_rise_irq) begin
            held_latch_nxt = 1'b0;
            clr = 1'b1;
          end
          if (item.key_short_irq) begin
            ev = ev | EV_PWR;
            clr = 1'b1;
          end
        end

        // Rate limit on emitted events.
        if (ev != 8'd0) begin
          if (!emit_open) begin
            ev = 8'd0;
          end else begin
            last_emit_time_nxt = item.now_ms;
          end
        end
      end
      default: ;
    endcase

    res.events    = ev;
    res.key_held  = held_latch_nxt & cfg.pmu_present;
    res.scan_done = scanned;
    res.clear_irq = clr;
  end

  // State registers advance once per item handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_inject_r   <= 8'd0;
      boot_armed_r       <= 1'b1;
      boot_start_valid_r <= 1'b0;
      boot_start_time_r  <= 32'd0;
      last_scan_time_r   <= 32'd0;
      held_latch_r       <= 1'b0;
      last_emit_time_r   <= 32'd0;
    end else if (fire) begin
      pending_inject_r   <= pending_inject_nxt;
      boot_armed_r       <= boot_armed_nxt;
      boot_start_valid_r <= boot_start_valid_nxt;
      boot_start_time_r  <= boot_start_time_nxt;
      last_scan_time_r   <= last_scan_time_nxt;
      held_latch_r       <= held_latch_nxt;
      last_emit_time_r   <= last_emit_time_nxt;
    end
  end

  // The boot event can only fire while armed, and disarms the qualifier.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.events[0] && !pending_inject_r[0] |=> !boot_armed_r)
    else $error("boot event did not disarm the qualifier");

  // A started hold timer is only ever cleared by a release.
  assert property (@(posedge clk) disable iff (!rst_n)
    boot_start_valid_r && !fire |=> boot_start_valid_r)
    else $error("hold timer lost without an item");

  // An interrupt clear request only comes out of a scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.clear_irq |-> res.scan_done)
    else $error("clear request without a scan");

endmodule

[rtl/side_button_event_qualifier.sv]
// An accepted transaction passes through the input register and then the result register;
// one transaction per cycle is accepted unless input stalls. The input register and the result
// register each hold one item, so input stalls only when both are full and out_tready is low.
// The state update for an item is one pass of compare logic in sbq_core.
// Reset (rst_n, synchronous, active low) empties both registers, loads the
// register defaults and returns the qualifier state to its idle values.
module side_button_event_qualifier
  import sbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: now_ms[31:0], boot_pressed[32], key_fall_irq[33], key_rise_irq[34],
  //        key_short_irq[35], inject_bits[43:36], hold_value[44], zero [47:45]
  input  logic [47:0] in_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: events[7:0], key_held[8], scan_done[9], clear_irq[10], zero [15:11]
  output logic [15:0] out_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    fire;

  // Configuration is always accepted.
  assign cfg_ready = 1'b1;

  sbq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Pipeline control: the input register moves on when the result register frees.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type      <= in_tuser;
      item_r.now_ms        <= in_tdata[31:0];
      item_r.boot_pressed  <= in_tdata[32];
      item_r.key_fall_irq  <= in_tdata[33];
      item_r.key_rise_irq  <= in_tdata[34];
      item_r.key_short_irq <= in_tdata[35];
      item_r.inject_bits   <= in_tdata[43:36];
      item_r.hold_value    <= in_tdata[44];
    end
  end

  sbq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.clear_irq, res_r.scan_done, res_r.key_held, res_r.events};

  // Input stalls only when both stages hold an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  // An item waiting in the input register is not dropped while the output stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("waiting item lost");

  // A delivered result is replaced only by a new item or the register empties.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tready && !in_valid_r |=> !out_valid_r)
    else $error("result repeated");

endmodule
